// ----- rtl/binary_trie_prefix_table_core_defines.svh -----
// Assertion macros shared by the prefix table checker.
// Needs nothing else; the file using them provides clk_i and rst_ni.
`ifndef BINARY_TRIE_PREFIX_TABLE_CORE_DEFINES_SVH
`define BINARY_TRIE_PREFIX_TABLE_CORE_DEFINES_SVH

// A property that holds at every clock edge outside of reset.
`define BTP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("prefix table check failed");

// A condition that must be followed by another one in the next cycle.
`define BTP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("prefix table sequence check failed");

`endif

// ----- rtl/btp_pkg.sv -----
// Package of the binary trie prefix table: word types, command and status codes.
// Used by the core, the checker and the testbench; depends on nothing.
package btp_pkg;

  localparam int VALUE_W = 32;
  localparam int CNT_W   = 13;

  typedef enum logic [1:0] {
    CMD_SET     = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_FIRST   = 2'd2,
    CMD_LONGEST = 2'd3
  } cmd_e;

  localparam logic [2:0] ST_NEW    = 3'd0;
  localparam logic [2:0] ST_DONE   = 3'd1;
  localparam logic [2:0] ST_NONE   = 3'd2;
  localparam logic [2:0] ST_BADARG = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;

  localparam logic [7:0] V4_BITS = 8'd32;
  localparam logic [7:0] V6_BITS = 8'd128;

  typedef struct packed {
    cmd_e               cmd;
    logic               is_v6;
    logic [63:0]        addr_hi;
    logic [63:0]        addr_lo;
    logic [7:0]         prefix_len;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [VALUE_W-1:0] value_out;
    logic [CNT_W-1:0]   count_v4;
    logic [CNT_W-1:0]   count_v6;
  } out_word_t;

endpackage

// ----- rtl/btp_node_ram.sv -----
// Node store of the prefix table: one write port, one registered read port.
// Depends on nothing.
module btp_node_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 56
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// ----- rtl/binary_trie_prefix_table_core.sv -----
// A rejected word goes from S_IDLE straight to S_RESP, which loads the output register once it is free;
// lookup, delete and set walk the trie level by level in S_WALK, a set then writes its missing nodes
// in S_ALLOC, and all of them end in S_RESP.
// Throughput: one word at a time; the next word can be taken once S_RESP has loaded the result register,
// with one node memory read per trie level walked.
// Reset (rst_ni low, asynchronous) empties both roots and zeroes the counts and free pointer;
module binary_trie_prefix_table_core #(
  parameter int NODES      = 4096,
  parameter int VALUE_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  btp_pkg::in_word_t    in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output btp_pkg::out_word_t   out_word_o
);

  // The node store is not cleared on reset, since only allocated nodes are ever linked.

  localparam int IDXW   = $clog2(NODES);
  localparam int CNTW   = $clog2(NODES + 2);
  localparam int VOUT_W = btp_pkg::VALUE_W;
  localparam int CNTO_W = btp_pkg::CNT_W;

  // One trie node: its value (zero means no prefix here) and two child links.
  typedef struct packed {
    logic [VALUE_BITS-1:0] val;
    logic                  has1;
    logic                  has0;
    logic [IDXW-1:0]       c1;
    logic [IDXW-1:0]       c0;
  } node_t;

  localparam int NW = $bits(node_t);

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_ALLOC = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0]            state_q, state_d;
  btp_pkg::in_word_t     req_q, req_d;
  logic                  use_root_q, use_root_d;
  logic [IDXW-1:0]       ptr_q, ptr_d;
  logic [7:0]            depth_q, depth_d;
  logic [VALUE_BITS-1:0] best_q, best_d;
  logic [IDXW-1:0]       alloc_q, alloc_d;
  logic [IDXW:0]         free_q, free_d;
  logic [CNTW-1:0]       cnt4_q, cnt4_d, cnt6_q, cnt6_d;
  logic [2:0]            rstat_q, rstat_d;
  logic [VALUE_BITS-1:0] rval_q, rval_d;
  node_t                 root_q [2];
  node_t                 root_d [2];
  logic                  out_valid_q, out_valid_d;
  btp_pkg::out_word_t    out_q, out_d;

  // Node memory ports.
  logic            wr_en, rd_en;
  logic [IDXW-1:0] wr_addr, rd_addr;
  node_t           wr_node;
  logic [NW-1:0]   rd_data;

  btp_node_ram #(
    .DEPTH (NODES),
    .WIDTH (NW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_node),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // The node under inspection is either the family's root register or the word
  // read from the store in the previous cycle.
  node_t                 cur;
  logic                  bit_now;
  logic                  has_b;
  logic [IDXW-1:0]       child;
  logic [7:0]            maxd;
  logic [VALUE_BITS-1:0] req_val;
  logic [VALUE_BITS-1:0] nbest;
  logic [7:0]            need;
  logic [IDXW+1:0]       free_sum;
  logic                  is_lookup;
  logic                  is_first;
  logic                  out_free;
  logic [7:0]            in_maxd;
  logic [VALUE_BITS-1:0] in_val;
  node_t                 upd;

  assign cur       = use_root_q ? root_q[req_q.is_v6] : node_t'(rd_data);
  // Address bits are walked from bit 127 down; depth d picks bit 127-d.
  assign bit_now   = depth_q[6] ? req_q.addr_lo[~depth_q[5:0]] : req_q.addr_hi[~depth_q[5:0]];
  assign has_b     = bit_now ? cur.has1 : cur.has0;
  assign child     = bit_now ? cur.c1 : cur.c0;
  assign maxd      = req_q.is_v6 ? btp_pkg::V6_BITS : btp_pkg::V4_BITS;
  assign req_val   = VALUE_BITS'(req_q.value);
  assign nbest     = (cur.val != '0) ? cur.val : best_q;
  assign need      = req_q.prefix_len - depth_q;
  assign free_sum  = {1'b0, free_q} + (IDXW+2)'(need);
  assign is_lookup = (req_q.cmd == btp_pkg::CMD_FIRST) || (req_q.cmd == btp_pkg::CMD_LONGEST);
  assign is_first  = (req_q.cmd == btp_pkg::CMD_FIRST);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_maxd   = in_word_i.is_v6 ? btp_pkg::V6_BITS : btp_pkg::V4_BITS;
  assign in_val    = VALUE_BITS'(in_word_i.value);

  // Words are taken only between items; a finished result may still wait
  // in the output register while the next word is accepted.
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    use_root_d  = use_root_q;
    ptr_d       = ptr_q;
    depth_d     = depth_q;
    best_d      = best_q;
    alloc_d     = alloc_q;
    free_d      = free_q;
    cnt4_d      = cnt4_q;
    cnt6_d      = cnt6_q;
    rstat_d     = rstat_q;
    rval_d      = rval_q;
    root_d      = root_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    wr_en       = 1'b0;
    wr_addr     = ptr_q;
    wr_node     = cur;
    rd_en       = 1'b0;
    rd_addr     = child;
    upd         = cur;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d      = in_word_i;
          use_root_d = 1'b1;
          depth_d    = '0;
          best_d     = '0;
          rval_d     = '0;
          rstat_d    = btp_pkg::ST_NONE;
          // Argument checks: prefix too long on set or delete, zero value on set.
          if (((in_word_i.cmd == btp_pkg::CMD_SET) || (in_word_i.cmd == btp_pkg::CMD_DELETE))
              && (in_word_i.prefix_len > in_maxd)) begin
            rstat_d = btp_pkg::ST_BADARG;
            state_d = S_RESP;
          end else if ((in_word_i.cmd == btp_pkg::CMD_SET) && (in_val == '0)) begin
            rstat_d = btp_pkg::ST_BADARG;
            state_d = S_RESP;
          end else begin
            state_d = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (is_lookup) begin
          best_d = nbest;
          if ((is_first && (nbest != '0)) || (depth_q == maxd) || !has_b) begin
            rstat_d = (nbest != '0) ? btp_pkg::ST_DONE : btp_pkg::ST_NONE;
            rval_d  = nbest;
            state_d = S_RESP;
          end else begin
            rd_en      = 1'b1;
            ptr_d      = child;
            use_root_d = 1'b0;
            depth_d    = depth_q + 8'd1;
          end
        end else if (depth_q == req_q.prefix_len) begin
          // The prefix's own node is reached.
          if (req_q.cmd == btp_pkg::CMD_SET) begin
            rstat_d = (cur.val == '0) ? btp_pkg::ST_NEW : btp_pkg::ST_DONE;
            rval_d  = cur.val;
            upd.val = req_val;
            if (cur.val == '0) begin
              if (req_q.is_v6) cnt6_d = cnt6_q + 1'b1;
              else             cnt4_d = cnt4_q + 1'b1;
            end
          end else if (cur.val != '0) begin
            rstat_d = btp_pkg::ST_DONE;
            rval_d  = cur.val;
            upd.val = '0;
            if (req_q.is_v6) begin
              if (cnt6_q != '0) cnt6_d = cnt6_q - 1'b1;
            end else begin
              if (cnt4_q != '0) cnt4_d = cnt4_q - 1'b1;
            end
          end
          if (use_root_q) begin
            root_d[req_q.is_v6] = upd;
          end else begin
            wr_en   = 1'b1;
            wr_node = upd;
          end
          state_d = S_RESP;
        end else if (!has_b) begin
          // The path ends early: a delete misses, a set grows a chain of nodes or reports the store full.
          if (req_q.cmd == btp_pkg::CMD_DELETE) begin
            state_d = S_RESP;
          end else if (free_sum > (IDXW+2)'(NODES)) begin
            rstat_d = btp_pkg::ST_FULL;
            state_d = S_RESP;
          end else begin
            if (bit_now) begin
              upd.has1 = 1'b1;
              upd.c1   = free_q[IDXW-1:0];
            end else begin
              upd.has0 = 1'b1;
              upd.c0   = free_q[IDXW-1:0];
            end
            if (use_root_q) begin
              root_d[req_q.is_v6] = upd;
            end else begin
              wr_en   = 1'b1;
              wr_node = upd;
            end
            alloc_d = free_q[IDXW-1:0];
            free_d  = free_sum[IDXW:0];
            depth_d = depth_q + 8'd1;
            rstat_d = btp_pkg::ST_NEW;
            if (req_q.is_v6) cnt6_d = cnt6_q + 1'b1;
            else             cnt4_d = cnt4_q + 1'b1;
            state_d = S_ALLOC;
          end
        end else begin
          rd_en      = 1'b1;
          ptr_d      = child;
          use_root_d = 1'b0;
          depth_d    = depth_q + 8'd1;
        end
      end

      S_ALLOC: begin
        // One new node per cycle; each links to the next, the last holds the value.
        wr_en   = 1'b1;
        wr_addr = alloc_q;
        wr_node = '0;
        if (depth_q == req_q.prefix_len) begin
          wr_node.val = req_val;
          state_d     = S_RESP;
        end else begin
          if (bit_now) begin
            wr_node.has1 = 1'b1;
            wr_node.c1   = IDXW'(alloc_q + 1'b1);
          end else begin
            wr_node.has0 = 1'b1;
            wr_node.c0   = IDXW'(alloc_q + 1'b1);
          end
          alloc_d = IDXW'(alloc_q + 1'b1);
          depth_d = depth_q + 8'd1;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.status        = rstat_q;
          out_d.value_out     = VOUT_W'(rval_q);
          out_d.count_v4      = CNTO_W'(cnt4_q);
          out_d.count_v6      = CNTO_W'(cnt6_q);
          state_d             = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_q      <= '0;
      cnt4_q      <= '0;
      cnt6_q      <= '0;
      root_q[0]   <= '0;
      root_q[1]   <= '0;
      out_valid_q <= 1'b0;
      use_root_q  <= 1'b1;
    end else begin
      state_q     <= state_d;
      free_q      <= free_d;
      cnt4_q      <= cnt4_d;
      cnt6_q      <= cnt6_d;
      root_q      <= root_d;
      out_valid_q <= out_valid_d;
      use_root_q  <= use_root_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    ptr_q   <= ptr_d;
    depth_q <= depth_d;
    best_q  <= best_d;
    alloc_q <= alloc_d;
    rstat_q <= rstat_d;
    rval_q  <= rval_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ----- rtl/btp_checker.sv -----
// Port-level checks of the prefix table's result channel, bound to the top level.
// Depends on btp_pkg and the assertion macro header.
`include "binary_trie_prefix_table_core_defines.svh"

module btp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input btp_pkg::out_word_t out_word_o
);

  `BTP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o))
  `BTP_ASSERT(a_status_range, !out_valid_o || (out_word_o.status <= btp_pkg::ST_FULL))
  `BTP_ASSERT(a_zero_on_miss, !(out_valid_o && ((out_word_o.status == btp_pkg::ST_NONE) || (out_word_o.status == btp_pkg::ST_BADARG) || (out_word_o.status == btp_pkg::ST_FULL) || (out_word_o.status == btp_pkg::ST_NEW))) || (out_word_o.value_out == '0))
  `BTP_ASSERT(a_done_nonzero, !(out_valid_o && (out_word_o.status == btp_pkg::ST_DONE)) || (out_word_o.value_out != '0))

endmodule

bind binary_trie_prefix_table_core btp_checker u_btp_checker (.*);

// ----- tb/btp_checker.sv -----
// Checker for the binary trie prefix table: watches both channels, predicts each result word.
// Depends on btp_pkg for the word types, command enum and status codes.
module btp_scoreboard #(
  parameter int NODES = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  btp_pkg::in_word_t  in_word_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  btp_pkg::out_word_t out_word_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import btp_pkg::*;

  // Roots live at NODES (IPv4) and NODES+1 (IPv6).
  logic [31:0] node_val [NODES+2];
  int          node_kid [NODES+2][2];
  bit          node_has [NODES+2][2];
  int          free_ptr;
  logic [12:0] count_v4, count_v6;
  out_word_t   expected_q[$];

  assign pending_o = expected_q.size();

  function automatic logic path_bit(input logic [63:0] hi, input logic [63:0] lo, input int i);
    return (i < 64) ? hi[63-i] : lo[127-i];
  endfunction

  function automatic int walk(input int n, input logic b);
    return node_has[n][b] ? node_kid[n][b] : -1;
  endfunction

  function automatic out_word_t predict_result(input in_word_t w);
    out_word_t   r;
    int          cur, nxt, need, maxd, i;
    logic        b;
    logic [31:0] best;
    cur  = NODES + int'(w.is_v6);
    maxd = w.is_v6 ? 128 : 32;
    r.status    = ST_NONE;
    r.value_out = '0;
    case (w.cmd)
      CMD_SET: begin
        if (w.prefix_len > maxd || w.value == 0) begin
          r.status = ST_BADARG;
        end else begin
          need = 0;
          nxt  = cur;
          for (i = 0; i < w.prefix_len; i++) begin
            nxt = walk(nxt, path_bit(w.addr_hi, w.addr_lo, i));
            if (nxt < 0) begin
              need = w.prefix_len - i;
              break;
            end
          end
          if (free_ptr + need > NODES) begin
            r.status = ST_FULL;
          end else begin
            for (i = 0; i < w.prefix_len; i++) begin
              b   = path_bit(w.addr_hi, w.addr_lo, i);
              nxt = walk(cur, b);
              if (nxt < 0) begin
                nxt = free_ptr++;
                node_val[nxt] = '0;
                node_has[nxt][0] = 0;
                node_has[nxt][1] = 0;
                node_kid[cur][b] = nxt;
                node_has[cur][b] = 1;
              end
              cur = nxt;
            end
            r.value_out = node_val[cur];
            r.status    = (node_val[cur] == 0) ? ST_NEW : ST_DONE;
            if (node_val[cur] == 0) begin
              if (w.is_v6) count_v6++;
              else count_v4++;
            end
            node_val[cur] = w.value;
          end
        end
      end
      CMD_DELETE: begin
        if (w.prefix_len > maxd) begin
          r.status = ST_BADARG;
        end else begin
          for (i = 0; i < w.prefix_len && cur >= 0; i++)
            cur = walk(cur, path_bit(w.addr_hi, w.addr_lo, i));
          if (cur >= 0 && node_val[cur] != 0) begin
            r.value_out = node_val[cur];
            node_val[cur] = '0;
            if (w.is_v6) begin
              if (count_v6 != 0) count_v6--;
            end else begin
              if (count_v4 != 0) count_v4--;
            end
            r.status = ST_DONE;
          end
        end
      end
      default: begin
        best = node_val[cur];
        for (i = 0; i < maxd && !(w.cmd == CMD_FIRST && best != 0); i++) begin
          cur = walk(cur, path_bit(w.addr_hi, w.addr_lo, i));
          if (cur < 0) break;
          if (node_val[cur] != 0) best = node_val[cur];
        end
        if (best != 0) begin
          r.value_out = best;
          r.status    = ST_DONE;
        end
      end
    endcase
    r.count_v4 = count_v4;
    r.count_v6 = count_v6;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w;
    if (!rst_ni) begin
      for (int f = 0; f < 2; f++) begin
        node_val[NODES+f] = '0;
        node_has[NODES+f][0] = 0;
        node_has[NODES+f][1] = 0;
      end
      free_ptr = 0;
      count_v4 = '0;
      count_v6 = '0;
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result word with nothing expected: %h", $time, out_word_i);
          fail_count_o++;
        end else begin
          exp_w = expected_q.pop_front();
          if (out_word_i.status !== exp_w.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_w.status, out_word_i.status);
            fail_count_o++;
          end
          if (out_word_i.value_out !== exp_w.value_out) begin
            $display("%0t: value_out expected %h actual %h", $time,
                     exp_w.value_out, out_word_i.value_out);
            fail_count_o++;
          end
          if (out_word_i.count_v4 !== exp_w.count_v4) begin
            $display("%0t: count_v4 expected %0d actual %0d", $time,
                     exp_w.count_v4, out_word_i.count_v4);
            fail_count_o++;
          end
          if (out_word_i.count_v6 !== exp_w.count_v6) begin
            $display("%0t: count_v6 expected %0d actual %0d", $time,
                     exp_w.count_v6, out_word_i.count_v6);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(predict_result(in_word_i));
    end
  end
endmodule

// ----- tb/tb_top.sv -----
// Top of the prefix table testbench: clock, reset, word stimulus, stalls and the verdict.
// Depends on btp_pkg, binary_trie_prefix_table_core and btp_scoreboard.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import btp_pkg::*;

  localparam int NODES      = 4096;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;
  int        fail_count, pending;

  // Idle rates in percent for each side, and the long receiver hold-off.
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  bit        recv_hold = 0;
  int        quiet_cycles = 0;

  // Address pools keep random words on shared trie paths so lookups and
  // deletes find what earlier sets stored.
  logic [31:0] v4_pool [8];
  logic [63:0] v6_hi_pool [8];
  logic [63:0] v6_lo_pool [8];

  binary_trie_prefix_table_core #(.NODES(NODES), .VALUE_BITS(32)) i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o
  );

  btp_scoreboard #(.NODES(NODES)) i_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_word_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_word_i(out_word_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver stalls at random, or solidly while a hold-off runs.
  always @(negedge clk_i) begin
    out_stall_i = recv_hold ? 1'b1 : ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: a long run of cycles with no word moving on either side ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Offers one word at a falling edge and holds it until the block takes it.
  // The stall is read after the block has settled from the last rising edge.
  task automatic offer_word(input in_word_t w);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_word_i  = w;
    do begin
      #1 taken = !in_stall_o;
      @(negedge clk_i);
    end while (!taken);
    in_valid_i = 1'b0;
  endtask

  function automatic in_word_t mk(input cmd_e c, input logic v6, input logic [63:0] hi,
                                  input logic [63:0] lo, input logic [7:0] plen,
                                  input logic [31:0] val);
    in_word_t w;
    w.cmd = c;
    w.is_v6 = v6;
    w.addr_hi = hi;
    w.addr_lo = lo;
    w.prefix_len = plen;
    w.value = val;
    return w;
  endfunction

  // Random word: mostly pool addresses with random tails and sane lengths,
  // some fully random noise, some out-of-range lengths and zero values.
  function automatic in_word_t random_word();
    in_word_t w;
    int       k, sel;
    k = $urandom_range(7);
    sel = $urandom_range(99);
    w.cmd   = cmd_e'($urandom_range(3));
    w.is_v6 = 1'($urandom_range(1));
    w.addr_lo = {$urandom, $urandom};
    w.value   = (sel < 5) ? 32'd0 : ((sel < 10) ? 32'hFFFF_FFFF : $urandom);
    if (w.is_v6) begin
      w.addr_hi = v6_hi_pool[k];
      if ($urandom_range(3) == 0) w.addr_lo = v6_lo_pool[k];
      w.prefix_len = (sel < 80) ? 8'($urandom_range(48)) : 8'($urandom_range(128));
    end else begin
      w.addr_hi = {v4_pool[k], $urandom};
      w.prefix_len = 8'($urandom_range(32));
    end
    if (sel >= 90 && sel < 95) w.prefix_len = 8'($urandom_range(255));
    if (sel >= 95) begin
      w.addr_hi = {$urandom, $urandom};
      w.prefix_len = 8'($urandom_range(20));
    end
    return w;
  endfunction

  task automatic run_random(input int n);
    repeat (n) offer_word(random_word());
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [63:0] h6, l6;
    for (int k = 0; k < 8; k++) begin
      v4_pool[k]    = $urandom;
      v6_hi_pool[k] = {$urandom, $urandom};
      v6_lo_pool[k] = {$urandom, $urandom};
    end
    h6 = v6_hi_pool[0];
    l6 = v6_lo_pool[0];
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed words: empty lookups, both length extremes, bad lengths,
    // zero value, replacement, both match kinds, deletes found and absent.
    offer_word(mk(CMD_LONGEST, 1'b0, '1, '1, 8'd0, 32'd0));
    offer_word(mk(CMD_DELETE, 1'b1, h6, l6, 8'd5, 32'd0));
    offer_word(mk(CMD_SET, 1'b0, '0, '0, 8'd0, 32'h0000_0001));
    offer_word(mk(CMD_SET, 1'b0, '1, '1, 8'd32, 32'hFFFF_FFFF));
    offer_word(mk(CMD_SET, 1'b0, '1, '0, 8'd33, 32'h1234_5678));
    offer_word(mk(CMD_SET, 1'b0, '1, '0, 8'd128, 32'h1234_5678));
    offer_word(mk(CMD_SET, 1'b0, '1, '0, 8'd16, 32'd0));
    offer_word(mk(CMD_SET, 1'b0, '1, '0, 8'd16, 32'hAAAA_5555));
    offer_word(mk(CMD_SET, 1'b0, '1, '0, 8'd16, 32'h5555_AAAA));
    offer_word(mk(CMD_FIRST, 1'b0, '1, '0, 8'd255, 32'hFFFF_FFFF));
    offer_word(mk(CMD_LONGEST, 1'b0, '1, '0, 8'd7, 32'd9));
    offer_word(mk(CMD_LONGEST, 1'b0, '1, '1, 8'd0, 32'd0));
    offer_word(mk(CMD_SET, 1'b1, h6, l6, 8'd128, 32'hDEAD_BEEF));
    offer_word(mk(CMD_SET, 1'b1, h6, l6, 8'd129, 32'hDEAD_BEEF));
    offer_word(mk(CMD_SET, 1'b1, h6, '0, 8'd64, 32'h0BAD_F00D));
    offer_word(mk(CMD_LONGEST, 1'b1, h6, l6, 8'd0, 32'd0));
    offer_word(mk(CMD_FIRST, 1'b1, h6, l6, 8'd0, 32'd0));
    offer_word(mk(CMD_LONGEST, 1'b1, ~h6, l6, 8'd0, 32'd0));
    offer_word(mk(CMD_DELETE, 1'b1, h6, l6, 8'd255, 32'd0));
    offer_word(mk(CMD_DELETE, 1'b1, h6, l6, 8'd128, 32'd0));
    offer_word(mk(CMD_DELETE, 1'b1, h6, l6, 8'd128, 32'd0));
    offer_word(mk(CMD_DELETE, 1'b0, '1, '1, 8'd32, 32'd0));
    offer_word(mk(CMD_DELETE, 1'b0, '0, '0, 8'd40, 32'd0));
    offer_word(mk(CMD_LONGEST, 1'b0, '0, '0, 8'd0, 32'd0));

    // First phase: sparse sender, busy receiver. A long hold-off on the
    // receiver lets the block fill up and push back on its input.
    send_idle_pct = 30;
    recv_idle_pct = 72;
    fork
      begin
        recv_hold = 1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        recv_hold = 0;
      end
    join_none
    run_random(160);

    // The sender pauses here until every expected word has come back.
    wait_drained();
    send_idle_pct = 72;
    recv_idle_pct = 30;
    run_random(160);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(160);

    // Exhaust the node store with unrelated /128 IPv6 prefixes, then send more random words.
    repeat (40) offer_word(mk(CMD_SET, 1'b1, {$urandom, $urandom}, {$urandom, $urandom},
                              8'd128, $urandom | 32'd1));
    run_random(20);

    wait_drained();
    repeat (300) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
